// ===== hdl/plce_pkg.sv =====
`timescale 1ns / 1ps

package plce_pkg;

	// fraction bits of the segment ratio, Q0.16
	localparam int FRAC_BITS = 16;
	localparam int CNT_W = $clog2(FRAC_BITS);

	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 2;
	localparam logic [APB_ADDR_W-1:0] REG_POINT_COUNT = 2'd0;

	typedef enum logic {
		KIND_WRITE = 1'b0,
		KIND_EVAL  = 1'b1
	} kind_t;

	typedef struct packed {
		logic vld;
		logic full;
	} q_stat_t;

endpackage

// ===== hdl/plce_queue.sv =====
`timescale 1ns / 1ps

module plce_queue #(
	parameter int W = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  logic [W-1:0]    din,
	input  logic            pop,
	output logic [W-1:0]    dout,
	output plce_pkg::q_stat_t stat
);
	import plce_pkg::*;

	logic [W-1:0] ent_q [2];
	logic         wp_q;
	logic         rp_q;
	logic [1:0]   cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign dout      = ent_q[rp_q];
	assign stat.vld  = (cnt_q != 2'd0);
	assign stat.full = (cnt_q == 2'd2);

endmodule

// ===== hdl/plce_front.sv =====
`timescale 1ns / 1ps

module plce_front #(
	parameter int MAX_POINTS  = 16,
	parameter int VALUE_WIDTH = 16,
	localparam int IDX_W = $clog2(MAX_POINTS),
	localparam int ENT_W = 1 + IDX_W + 2 * VALUE_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_vld,
	output logic                   in_rdy,
	input  logic                   func,
	input  logic [IDX_W-1:0]       point_index,
	input  logic [VALUE_WIDTH-1:0] point_x,
	input  logic [VALUE_WIDTH-1:0] point_y,
	input  logic [VALUE_WIDTH-1:0] query_position,
	input  plce_pkg::q_stat_t      q_stat,
	output logic                   q_push,
	output logic [ENT_W-1:0]       q_din
);
	import plce_pkg::*;

	logic             vld_q;
	logic [ENT_W-1:0] ent_q;
	logic             take;
	logic             keep;
	kind_t            kind;
	logic [VALUE_WIDTH-1:0] a_val;

	// writes to a slot past the table are dropped here
	always_comb begin
		kind  = func ? KIND_EVAL : KIND_WRITE;
		a_val = (kind == KIND_EVAL) ? query_position : point_x;
		keep  = (kind == KIND_EVAL) ||
		        ({1'b0, point_index} < (IDX_W + 1)'(MAX_POINTS));
	end

	assign q_push = vld_q && !q_stat.full;
	assign in_rdy = !vld_q || !q_stat.full;
	assign take   = in_vld && in_rdy;
	assign q_din  = ent_q;

	always_ff @(posedge clk) begin
		if (take) begin
			ent_q <= {point_y, a_val, point_index, kind};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (take) begin
			vld_q <= keep;
		end else if (q_push) begin
			vld_q <= 1'b0;
		end
	end

endmodule

// ===== hdl/plce_back.sv =====
`timescale 1ns / 1ps

module plce_back #(
	parameter int MAX_POINTS  = 16,
	parameter int VALUE_WIDTH = 16,
	localparam int IDX_W = $clog2(MAX_POINTS),
	localparam int CW    = $clog2(MAX_POINTS + 1),
	localparam int ENT_W = 1 + IDX_W + 2 * VALUE_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [CW-1:0]          point_count,
	input  plce_pkg::q_stat_t      q_stat,
	input  logic [ENT_W-1:0]       q_dout,
	output logic                   q_pop,
	output logic                   out_vld,
	input  logic                   out_rdy,
	output logic [VALUE_WIDTH-1:0] curve_value
);
	import plce_pkg::*;

	localparam int VW = VALUE_WIDTH;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOAD = 3'd1;
	localparam logic [2:0] ST_SCAN = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_MUL  = 3'd4;
	localparam logic [2:0] ST_ADD  = 3'd5;
	localparam logic [2:0] ST_FIN  = 3'd6;

	logic [2:0] state_q;

	logic [2*VW-1:0] mem [MAX_POINTS];
	logic [2*VW-1:0] rd_q;
	logic [IDX_W-1:0] raddr;
	logic            we;

	kind_t            e_kind;
	logic [IDX_W-1:0] e_idx;
	logic [VW-1:0]    e_a;
	logic [VW-1:0]    e_b;

	logic signed [VW-1:0] t_q, x0_q, y0_q;
	logic signed [VW-1:0] rx, ry;
	logic [CW-1:0]        n_q, cur_q, nxt, n_clamp;
	logic [VW-1:0]        rem_q, den_q, mag_q;
	logic [FRAC_BITS-1:0] quot_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 neg_q;
	logic [VW+FRAC_BITS-1:0] prod_q;
	logic [VW-1:0]        res_q;
	logic [VW-1:0]        out_q;
	logic                 out_vld_q;
	logic                 out_load;

	logic signed [VW:0]   num_w, den_w, dy_w, sum_w;
	logic [VW:0]          dy_abs;
	logic [VW:0]          sh;
	logic [VW+1:0]        diff;
	logic                 ge;
	logic [VW-1:0]        scaled;

	assign {e_b, e_a, e_idx} = q_dout[ENT_W-1:1];
	assign e_kind = kind_t'(q_dout[0]);

	assign rx = rd_q[VW-1:0];
	assign ry = rd_q[2*VW-1:VW];

	assign nxt     = cur_q + CW'(1);
	assign n_clamp = (point_count > CW'(MAX_POINTS)) ? CW'(MAX_POINTS) : point_count;

	assign q_pop = (state_q == ST_IDLE) && q_stat.vld;
	assign we    = q_pop && (e_kind == KIND_WRITE);
	assign raddr = (state_q == ST_IDLE) ? '0 : nxt[IDX_W-1:0];

	// table: y in the upper half, x in the lower
	always_ff @(posedge clk) begin
		if (we) begin
			mem[e_idx] <= {e_b, e_a};
		end
		rd_q <= mem[raddr];
	end

	always_comb begin
		num_w  = {t_q[VW-1], t_q} - {x0_q[VW-1], x0_q};
		den_w  = {rx[VW-1], rx} - {x0_q[VW-1], x0_q};
		dy_w   = {ry[VW-1], ry} - {y0_q[VW-1], y0_q};
		dy_abs = dy_w[VW] ? (~dy_w + 1'b1) : dy_w;
		sh     = {rem_q, 1'b0};
		diff   = {1'b0, sh} - {2'b00, den_q};
		ge     = !diff[VW+1];
		scaled = prod_q[VW+FRAC_BITS-1:FRAC_BITS];
		sum_w  = neg_q ? ({y0_q[VW-1], y0_q} - {1'b0, scaled})
		               : ({y0_q[VW-1], y0_q} + {1'b0, scaled});
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (q_pop) begin
					t_q   <= e_a;
					n_q   <= n_clamp;
					cur_q <= '0;
					res_q <= '0;
				end
			end
			ST_LOAD: begin
				x0_q  <= rx;
				y0_q  <= ry;
				res_q <= ry;
				cur_q <= CW'(1);
			end
			ST_SCAN: begin
				if (t_q < rx) begin
					res_q  <= ry;
					rem_q  <= num_w[VW-1:0];
					den_q  <= den_w[VW-1:0];
					mag_q  <= dy_abs[VW-1:0];
					neg_q  <= dy_w[VW];
					quot_q <= '0;
					cnt_q  <= '0;
				end else begin
					x0_q  <= rx;
					y0_q  <= ry;
					res_q <= ry;
					cur_q <= nxt;
				end
			end
			ST_DIV: begin
				quot_q <= {quot_q[FRAC_BITS-2:0], ge};
				rem_q  <= ge ? diff[VW-1:0] : sh[VW-1:0];
				cnt_q  <= cnt_q + CNT_W'(1);
			end
			ST_MUL: begin
				prod_q <= mag_q * quot_q;
			end
			ST_ADD: begin
				res_q <= sum_w[VW-1:0];
			end
			ST_FIN: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop && e_kind == KIND_EVAL) begin
						state_q <= (n_clamp == '0) ? ST_FIN : ST_LOAD;
					end
				end
				ST_LOAD: begin
					if (t_q < rx || n_q == CW'(1)) begin
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (t_q < rx) begin
						// zero or negative width takes the right endpoint
						state_q <= (rx <= x0_q) ? ST_FIN : ST_DIV;
					end else if (nxt == n_q) begin
						state_q <= ST_FIN;
					end
				end
				ST_DIV: begin
					if (cnt_q == CNT_W'(FRAC_BITS - 1)) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_ADD;
				ST_ADD: state_q <= ST_FIN;
				ST_FIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// hold the result while the sink stalls; the next request may proceed until it reaches ST_FIN
	assign out_load = (state_q == ST_FIN) && (!out_vld_q || out_rdy);

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (out_rdy) begin
			out_vld_q <= 1'b0;
		end
	end

	assign out_vld     = out_vld_q;
	assign curve_value = out_q;

endmodule

// ===== hdl/piecewise_linear_curve_eval_top.sv =====
`timescale 1ns / 1ps

// Piecewise-linear curve evaluator. Write requests (tuser low) load one (x, y)
// breakpoint into the table and return nothing; evaluate requests (tuser high)
// return one signed Q8.8 curve value at query_position, clamped to the first y
// below the first x and to the last y at or beyond the last x of the
// point_count points in use (register at address 0). A two-entry queue sits
// between the input stage and the evaluator, so requests keep flowing while a
// result waits on the output. An evaluate reads the table one entry per cycle,
// walking at most MAX_POINTS - 1 segments, and when it interpolates it then runs
// a bit-serial fraction divide, one multiply and one add. It then waits while
// the previous result still waits on m_tready.
module piecewise_linear_curve_eval_top #(
	parameter int MAX_POINTS  = 16,
	parameter int VALUE_WIDTH = 16,
	localparam int IDX_W = $clog2(MAX_POINTS),
	localparam int CW    = $clog2(MAX_POINTS + 1),
	localparam int IN_W  = ((IDX_W + 3 * VALUE_WIDTH + 7) / 8) * 8,
	localparam int OUT_W = ((VALUE_WIDTH + 7) / 8) * 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// point_index, point_x, point_y, query_position, zero pad
	input  logic [IN_W-1:0]                     s_tdata,
	// func
	input  logic                                s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// curve_value, zero pad
	output logic [OUT_W-1:0]                    m_tdata,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [plce_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [plce_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [plce_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready
);
	import plce_pkg::*;

	localparam int VW    = VALUE_WIDTH;
	localparam int ENT_W = 1 + IDX_W + 2 * VW;

	logic [CW-1:0]    count_q;
	logic             q_push;
	logic             q_pop;
	logic [ENT_W-1:0] q_din;
	logic [ENT_W-1:0] q_dout;
	q_stat_t          q_stat;
	logic [VW-1:0]    curve_value;

	assign pready = 1'b1;
	assign prdata = (paddr == REG_POINT_COUNT) ? APB_DATA_W'(count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (psel && penable && pwrite && pready && paddr == REG_POINT_COUNT) begin
			count_q <= pwdata[CW-1:0];
		end
	end

	plce_front #(
		.MAX_POINTS (MAX_POINTS),
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_vld        (s_tvalid),
		.in_rdy        (s_tready),
		.func          (s_tuser),
		.point_index   (s_tdata[IDX_W-1:0]),
		.point_x       (s_tdata[IDX_W+VW-1:IDX_W]),
		.point_y       (s_tdata[IDX_W+2*VW-1:IDX_W+VW]),
		.query_position(s_tdata[IDX_W+3*VW-1:IDX_W+2*VW]),
		.q_stat        (q_stat),
		.q_push        (q_push),
		.q_din         (q_din)
	);

	plce_queue #(
		.W(ENT_W)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.din   (q_din),
		.pop   (q_pop),
		.dout  (q_dout),
		.stat  (q_stat)
	);

	plce_back #(
		.MAX_POINTS (MAX_POINTS),
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.point_count(count_q),
		.q_stat     (q_stat),
		.q_dout     (q_dout),
		.q_pop      (q_pop),
		.out_vld    (m_tvalid),
		.out_rdy    (m_tready),
		.curve_value(curve_value)
	);

	assign m_tdata = OUT_W'(curve_value);

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_stat.vld)
		else $error("evaluator pops an empty queue");

	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("front pushes into a full queue");

	a_ready_when_room: assert property (@(posedge clk) disable iff (!arst_n)
		!q_stat.full |-> s_tready)
		else $error("input stalled while the queue has room");

endmodule

// ===== sim/piecewise_linear_curve_eval_top_tb.sv =====
`timescale 1ns / 1ps

module piecewise_linear_curve_eval_top_tb;
	import plce_pkg::*;

	localparam int TOTAL_ITEMS   = 1250;
	localparam int CALM_AFTER    = 1100;
	localparam int SETTLE_CYCLES = 60;
	localparam int CYCLE_LIMIT   = 500000;

	typedef enum logic {STEP_REQ, STEP_SET_COUNT} step_kind_t;

	typedef struct {
		step_kind_t  op;
		kind_t       kind;
		logic [3:0]  idx;
		logic [15:0] px;
		logic [15:0] py;
		logic [15:0] pq;
		bit          typed;
		logic [15:0] val;
		logic [4:0]  count;
	} step_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	// point_index, point_x, point_y, query_position, zero pad
	logic [55:0] s_tdata;
	// func
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	// curve_value
	logic [15:0] m_tdata;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic        pready;

	// mirror of the block's table and register
	logic signed [15:0] bp_x [16];
	logic signed [15:0] bp_y [16];
	logic [4:0]  curve_points = 5'd0;

	logic [15:0] due_values [$];
	logic [15:0] want;
	step_t       plan [$];
	int          errors = 0;
	int          items_sent = 0;
	bit          idle_mode = 1'b1;
	int          ready_hold = 0;
	int unsigned cycle_count = 0;

	piecewise_linear_curve_eval_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #5 clk = ~clk;

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("** piecewise_linear_curve_eval_top: FAILED **");
		$finish;
	end

	function automatic logic [15:0] curve_at(logic signed [15:0] t);
		int n;
		longint x0, y0, x1, y1, num, den, frac, dy, mag, r;
		n = (curve_points > 5'd16) ? 16 : int'(curve_points);
		if (n == 0)
			return 16'd0;
		x0 = bp_x[0];
		y0 = bp_y[0];
		if (t < x0)
			return bp_y[0];
		for (int i = 0; i + 1 < n; i++) begin
			x1 = bp_x[i + 1];
			y1 = bp_y[i + 1];
			if (t < x1) begin
				if (x1 - x0 <= 0)
					return bp_y[i + 1];
				num = t - x0;
				den = x1 - x0;
				frac = (num << 16) / den;
				dy = y1 - y0;
				mag = (dy < 0) ? -dy : dy;
				mag = (mag * frac) >> 16;
				r = (dy < 0) ? y0 - mag : y0 + mag;
				return r[15:0];
			end
			x0 = x1;
			y0 = y1;
		end
		return y0[15:0];
	endfunction

	// aim most queries at breakpoints and the segments right after them
	function automatic logic [15:0] pick_query();
		int n, j, r;
		logic [15:0] base;
		n = (curve_points > 5'd16) ? 16 : int'(curve_points);
		r = $urandom_range(0, 9);
		if (r < 3 || n == 0)
			return 16'($urandom_range(0, 65535));
		if (r == 3)
			return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
		j = $urandom_range(0, n - 1);
		base = bp_x[j];
		case ($urandom_range(0, 3))
			0: return base;
			1: return base - 16'd1;
			2: return base + 16'd1;
			default: return base + 16'($urandom_range(0, 511));
		endcase
	endfunction

	function automatic step_t wr(logic [3:0] idx, logic [15:0] px, logic [15:0] py);
		step_t s;
		s = '{STEP_REQ, KIND_WRITE, idx, px, py, 16'd0, 1'b0, 16'd0, 5'd0};
		return s;
	endfunction

	function automatic step_t ev(logic [15:0] pq);
		step_t s;
		s = '{STEP_REQ, KIND_EVAL, 4'd0, 16'd0, 16'd0, pq, 1'b0, 16'd0, 5'd0};
		return s;
	endfunction

	function automatic step_t evk(logic [15:0] pq, logic [15:0] val);
		step_t s;
		s = '{STEP_REQ, KIND_EVAL, 4'd0, 16'd0, 16'd0, pq, 1'b1, val, 5'd0};
		return s;
	endfunction

	function automatic step_t setc(logic [4:0] c);
		step_t s;
		s = '{STEP_SET_COUNT, KIND_EVAL, 4'd0, 16'd0, 16'd0, 16'd0, 1'b0, 16'd0, c};
		return s;
	endfunction

	task automatic send_item(kind_t k, logic [3:0] idx, logic [15:0] px, logic [15:0] py,
			logic [15:0] pq, bit typed, logic [15:0] typed_val);
		if (idle_mode && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= k;
		s_tdata <= {4'd0, pq, py, px, idx};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (k == KIND_WRITE) begin
			bp_x[idx] = px;
			bp_y[idx] = py;
		end else begin
			due_values.push_back(typed ? typed_val : curve_at(pq));
		end
		items_sent++;
		@(negedge clk);
	endtask

	// let writes still in flight finish after the last result
	task automatic drain();
		s_tvalid <= 1'b0;
		while (due_values.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_point_count(logic [4:0] c);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_POINT_COUNT;
		pwdata <= {27'd0, c};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		curve_points = c;
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== {27'd0, c}) begin
			$display("%0t: point_count readback, expected %h, got %h", $time, {27'd0, c},
				prdata);
			errors++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// style 0: ascending x, 1: ascending with ties, 2: unordered
	task automatic load_table(int style);
		int xs [16];
		int pos, step_max, k, slot, stride, offset;
		stride = 2 * $urandom_range(0, 7) + 1;
		offset = $urandom_range(0, 15);
		pos = -32768 + int'($urandom_range(0, 3000));
		step_max = ($urandom_range(0, 2) == 0) ? 8 : 4000;
		for (k = 0; k < 16; k++) begin
			if (style == 2) begin
				xs[k] = $urandom_range(0, 65535);
			end else begin
				xs[k] = pos;
				pos += $urandom_range((style == 1) ? 0 : 1, step_max);
			end
		end
		for (k = 0; k < 16; k++) begin
			slot = (k * stride + offset) % 16;
			send_item(KIND_WRITE, slot[3:0], xs[slot][15:0], 16'($urandom_range(0, 65535)),
				16'($urandom_range(0, 65535)), 1'b0, 16'd0);
		end
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (due_values.size() == 0) begin
				$display("%0t: unexpected curve value, expected none, got %h", $time, m_tdata);
				errors++;
			end else begin
				want = due_values.pop_front();
				if (m_tdata !== want) begin
					$display("%0t: curve value mismatch, expected %h, got %h", $time, want,
						m_tdata);
					errors++;
				end
			end
		end
	end

	// result side back-pressure
	initial begin
		m_tready = 1'b1;
		forever begin
			@(negedge clk);
			if (ready_hold > 0) begin
				ready_hold--;
				m_tready <= 1'b0;
			end else if (idle_mode && $urandom_range(0, 7) == 0) begin
				ready_hold = $urandom_range(1, 18) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		int c, n_items, phase;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;

		// no points in use yet, then a small table with a tie and a step back in x
		plan.push_back(evk(16'h8000, 16'h0000));
		plan.push_back(evk(16'h7FFF, 16'h0000));
		plan.push_back(wr(4'd0, 16'hFF00, 16'h0100));
		plan.push_back(wr(4'd1, 16'h0000, 16'h7FFF));
		plan.push_back(wr(4'd2, 16'h0200, 16'h8000));
		plan.push_back(wr(4'd3, 16'h0200, 16'h1234));
		plan.push_back(wr(4'd4, 16'h0100, 16'h0042));
		plan.push_back(wr(4'd5, 16'h7FFF, 16'hFFFF));
		plan.push_back(evk(16'h1234, 16'h0000));
		plan.push_back(setc(5'd1));
		plan.push_back(evk(16'h8000, 16'h0100));
		plan.push_back(evk(16'h7FFF, 16'h0100));
		plan.push_back(evk(16'hFF00, 16'h0100));
		plan.push_back(setc(5'd6));
		plan.push_back(evk(16'h8000, 16'h0100));
		plan.push_back(evk(16'hFF00, 16'h0100));
		plan.push_back(ev(16'hFF80));
		plan.push_back(ev(16'hFFFF));
		plan.push_back(ev(16'h0000));
		plan.push_back(ev(16'h0080));
		plan.push_back(ev(16'h01FF));
		plan.push_back(ev(16'h0200));
		plan.push_back(ev(16'h0180));
		plan.push_back(evk(16'h7FFF, 16'hFFFF));
		plan.push_back(ev(16'h7FFE));

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		foreach (plan[p]) begin
			if (plan[p].op == STEP_SET_COUNT) begin
				drain();
				set_point_count(plan[p].count);
			end else begin
				send_item(plan[p].kind, plan[p].idx, plan[p].px, plan[p].py, plan[p].pq,
					plan[p].typed, plan[p].val);
			end
		end

		phase = 0;
		while (items_sent < TOTAL_ITEMS) begin
			drain();
			idle_mode = (items_sent < CALM_AFTER) && ($urandom_range(0, 3) != 0);
			case ($urandom_range(0, 9))
				0: c = 0;
				1: c = 1;
				2: c = 16;
				3: c = 31;
				4: c = $urandom_range(17, 31);
				default: c = $urandom_range(2, 16);
			endcase
			set_point_count(c[4:0]);
			// fill every slot first so no evaluate reads an unwritten entry
			if (phase == 0 || $urandom_range(0, 2) == 0)
				load_table(($urandom_range(0, 5) < 4) ? 0 : $urandom_range(1, 2));
			n_items = $urandom_range(20, 60);
			repeat (n_items) begin
				if ($urandom_range(0, 6) == 0)
					send_item(KIND_WRITE, 4'($urandom_range(0, 15)),
						16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
						16'($urandom_range(0, 65535)), 1'b0, 16'd0);
				else
					send_item(KIND_EVAL, 4'($urandom_range(0, 15)),
						16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
						pick_query(), 1'b0, 16'd0);
			end
			phase++;
		end

		drain();
		if (errors == 0)
			$display("** piecewise_linear_curve_eval_top: PASSED **");
		else
			$display("** piecewise_linear_curve_eval_top: FAILED **");
		$finish;
	end

endmodule
